### src/rrb_pkg.sv
// Shared types and constants for the receive reorder buffer.
// No dependencies; used by rx_reorder_buffer, rrb_front and rrb_back.
package rrb_pkg;

  localparam int SLOT_COUNT_DEF = 16;
  localparam int TAG_WIDTH      = 16;
  localparam int NUM_WIDTH      = 32;
  localparam int LEN_WIDTH      = 16;
  localparam int WIN_WIDTH      = 5;
  localparam int QUEUE_DEPTH    = 2;

  localparam logic [1:0] KIND_STORE   = 2'd0;
  localparam logic [1:0] KIND_ADVANCE = 2'd1;
  localparam logic [1:0] KIND_CLEAR   = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;

  typedef enum logic [1:0] {
    OP_STORE,
    OP_ADVANCE,
    OP_CLEAR,
    OP_REJECT
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_STORE,
    S_ADV
  } state_t;

  typedef struct packed {
    logic [1:0]           kind;
    logic [NUM_WIDTH-1:0] seq_num;
    logic [TAG_WIDTH-1:0] payload_tag;
    logic [LEN_WIDTH-1:0] payload_length;
  } item_t;

  typedef struct packed {
    logic [1:0]           status;
    logic                 delivered;
    logic [NUM_WIDTH-1:0] out_number;
    logic [TAG_WIDTH-1:0] out_tag;
    logic                 last;
  } result_t;

  typedef struct packed {
    op_t                  op;
    logic [NUM_WIDTH-1:0] number;
    logic [TAG_WIDTH-1:0] tag;
  } cmd_t;

endpackage

### src/rx_reorder_buffer.sv
// Receive reorder buffer top; depends on rrb_pkg, rrb_front, rrb_back and rrb_ram.
// done is registered. Clear and reject run in S_IDLE, a store goes on to S_STORE, and an
// advance goes on to S_ADV and stays while the expected packet is held, raising done for
// each drained packet (last marks the final one), or once with nothing delivered if none drains.
// A two-entry request queue lets start be taken while the executor works; results cannot stall.
// Synchronous reset empties all slots, expected number 0, window min(SLOT_COUNT, 16).
module rx_reorder_buffer #(
  parameter int SLOT_COUNT = rrb_pkg::SLOT_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  rrb_pkg::item_t                item,
  output logic                          busy,
  input  logic                          window_we,
  input  logic [rrb_pkg::WIN_WIDTH-1:0] window_cfg,
  output logic                          done,
  output rrb_pkg::result_t              result
);
  import rrb_pkg::*;

  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;

  rrb_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .item      (item),
    .busy      (busy),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  rrb_back #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_pop    (cmd_pop),
    .window_we  (window_we),
    .window_cfg (window_cfg),
    .done       (done),
    .result     (result)
  );

endmodule

### src/rrb_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module rrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/rrb_front.sv
// Request intake: classifies each request into a command and queues it.
// Depends on rrb_pkg.
module rrb_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  rrb_pkg::item_t item,
  output logic          busy,
  output logic          cmd_valid,
  output rrb_pkg::cmd_t cmd,
  input  logic          cmd_pop
);
  import rrb_pkg::*;

  localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          q [QUEUE_DEPTH];
  logic [QW-1:0] wr_ptr;
  logic [QW-1:0] rd_ptr;
  logic [CW-1:0] cnt;
  logic          push;
  cmd_t          new_cmd;

  always_comb begin
    new_cmd.number = item.seq_num;
    new_cmd.tag    = item.payload_tag;
    case (item.kind)
      KIND_STORE: begin
        new_cmd.op = (item.payload_length == '0) ? OP_REJECT : OP_STORE;
      end
      KIND_ADVANCE: begin
        new_cmd.op = OP_ADVANCE;
      end
      KIND_CLEAR: begin
        new_cmd.op = OP_CLEAR;
      end
      default: begin
        new_cmd.op = OP_REJECT;
      end
    endcase
  end

  assign busy      = (cnt == CW'(QUEUE_DEPTH));
  assign push      = start && !busy;
  assign cmd_valid = (cnt != '0);
  assign cmd       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= new_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (cmd_pop) begin
        rd_ptr <= (rd_ptr == QW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !cmd_pop) begin
        cnt <= cnt + 1'b1;
      end else if (!push && cmd_pop) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

endmodule

### src/rrb_back.sv
// Command executor: window checks, slot store, in-order drain, result register.
// Depends on rrb_pkg and rrb_ram.
module rrb_back #(
  parameter int SLOT_COUNT = rrb_pkg::SLOT_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cmd_valid,
  input  rrb_pkg::cmd_t                 cmd,
  output logic                          cmd_pop,
  input  logic                          window_we,
  input  logic [rrb_pkg::WIN_WIDTH-1:0] window_cfg,
  output logic                          done,
  output rrb_pkg::result_t              result
);
  import rrb_pkg::*;

  localparam int IW = $clog2(SLOT_COUNT);
  localparam int CW = $clog2(SLOT_COUNT + 1);
  localparam int DW = NUM_WIDTH + TAG_WIDTH;
  localparam int WIN_RESET = (SLOT_COUNT < 16) ? SLOT_COUNT : 16;

  function automatic logic [WIN_WIDTH-1:0] clamp_win(input logic [WIN_WIDTH-1:0] ws);
    logic [WIN_WIDTH-1:0] w;
    w = (ws == '0) ? WIN_WIDTH'(1) : ws;
    if (32'(w) > 32'(SLOT_COUNT)) begin
      w = WIN_WIDTH'(SLOT_COUNT);
    end
    return w;
  endfunction

  state_t                 state, state_next;
  logic [NUM_WIDTH-1:0]   expected, expected_next;
  logic [IW-1:0]          exp_idx, exp_idx_next;
  logic [CW-1:0]          held, held_next;
  logic [SLOT_COUNT-1:0]  valid_bits, valid_next;
  logic [WIN_WIDTH-1:0]   win;
  cmd_t                   cur, cur_next;
  logic [IW-1:0]          st_idx, st_idx_next;
  logic                   st_full, st_full_next;
  logic [CW-1:0]          rel_cnt, rel_cnt_next;
  logic                   pend_valid, pend_valid_next;
  logic [NUM_WIDTH-1:0]   pend_num, pend_num_next;
  logic [TAG_WIDTH-1:0]   pend_tag, pend_tag_next;
  logic                   done_next;
  result_t                result_next;

  logic                   ram_we;
  logic [IW-1:0]          ram_waddr;
  logic [DW-1:0]          ram_wdata;
  logic [IW-1:0]          ram_raddr;
  logic [DW-1:0]          ram_rdata;
  logic [NUM_WIDTH-1:0]   rd_num;
  logic [TAG_WIDTH-1:0]   rd_tag;

  logic [NUM_WIDTH-1:0]   off;
  logic                   in_win;
  logic                   held_full;
  logic [IW:0]            idx_sum;
  logic [IW-1:0]          store_idx;
  logic [IW-1:0]          exp_inc_idx;
  logic                   hit;

  rrb_ram #(
    .WIDTH (DW),
    .DEPTH (SLOT_COUNT)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_num = ram_rdata[DW-1:TAG_WIDTH];
  assign rd_tag = ram_rdata[TAG_WIDTH-1:0];

  assign off       = cmd.number - expected;
  assign in_win    = (off < 32'(win));
  assign held_full = (32'(held) >= 32'(win));
  assign idx_sum   = {1'b0, exp_idx} + {1'b0, off[IW-1:0]};
  assign store_idx = (idx_sum >= (IW+1)'(SLOT_COUNT)) ?
                     IW'(idx_sum - (IW+1)'(SLOT_COUNT)) : idx_sum[IW-1:0];
  assign exp_inc_idx = (exp_idx == IW'(SLOT_COUNT - 1)) ? '0 : exp_idx + 1'b1;
  assign hit = (rel_cnt != CW'(SLOT_COUNT)) && valid_bits[exp_idx] &&
               (rd_num == expected);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd_valid && cmd.op == OP_STORE) begin
          state_next = S_STORE;
        end else if (cmd_valid && cmd.op == OP_ADVANCE) begin
          state_next = S_ADV;
        end
      end
      S_STORE: begin
        state_next = S_IDLE;
      end
      S_ADV: begin
        if (!hit) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_pop         = 1'b0;
    ram_we          = 1'b0;
    ram_waddr       = st_idx;
    ram_wdata       = {cur.number, cur.tag};
    ram_raddr       = exp_inc_idx;
    expected_next   = expected;
    exp_idx_next    = exp_idx;
    held_next       = held;
    valid_next      = valid_bits;
    cur_next        = cur;
    st_idx_next     = st_idx;
    st_full_next    = st_full;
    rel_cnt_next    = rel_cnt;
    pend_valid_next = pend_valid;
    pend_num_next   = pend_num;
    pend_tag_next   = pend_tag;
    done_next       = 1'b0;
    result_next     = '{status: ST_OK, delivered: 1'b0, out_number: '0,
                        out_tag: '0, last: 1'b1};
    case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_pop  = 1'b1;
          cur_next = cmd;
          case (cmd.op)
            OP_STORE: begin
              ram_raddr    = store_idx;
              st_idx_next  = store_idx;
              st_full_next = !in_win || held_full;
            end
            OP_ADVANCE: begin
              expected_next   = expected + 1'b1;
              exp_idx_next    = exp_inc_idx;
              ram_raddr       = exp_inc_idx;
              rel_cnt_next    = '0;
              pend_valid_next = 1'b0;
            end
            OP_CLEAR: begin
              valid_next = '0;
              held_next  = '0;
              done_next  = 1'b1;
            end
            default: begin
              done_next          = 1'b1;
              result_next.status = ST_INVALID;
            end
          endcase
        end
      end
      S_STORE: begin
        done_next = 1'b1;
        if (st_full) begin
          result_next.status = ST_FULL;
        end else if (!(valid_bits[st_idx] && rd_num == cur.number)) begin
          ram_we              = 1'b1;
          valid_next[st_idx]  = 1'b1;
          if (!valid_bits[st_idx]) begin
            held_next = held + 1'b1;
          end
        end
      end
      S_ADV: begin
        if (hit) begin
          valid_next[exp_idx] = 1'b0;
          if (held != '0) begin
            held_next = held - 1'b1;
          end
          expected_next   = expected + 1'b1;
          exp_idx_next    = exp_inc_idx;
          ram_raddr       = exp_inc_idx;
          rel_cnt_next    = rel_cnt + 1'b1;
          pend_valid_next = 1'b1;
          pend_num_next   = rd_num;
          pend_tag_next   = rd_tag;
          if (pend_valid) begin
            done_next              = 1'b1;
            result_next.delivered  = 1'b1;
            result_next.out_number = pend_num;
            result_next.out_tag    = pend_tag;
            result_next.last       = 1'b0;
          end
        end else begin
          done_next = 1'b1;
          if (pend_valid) begin
            result_next.delivered  = 1'b1;
            result_next.out_number = pend_num;
            result_next.out_tag    = pend_tag;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      expected   <= '0;
      exp_idx    <= '0;
      held       <= '0;
      valid_bits <= '0;
      win        <= WIN_WIDTH'(WIN_RESET);
      pend_valid <= 1'b0;
      done       <= 1'b0;
    end else begin
      state      <= state_next;
      expected   <= expected_next;
      exp_idx    <= exp_idx_next;
      held       <= held_next;
      valid_bits <= valid_next;
      pend_valid <= pend_valid_next;
      done       <= done_next;
      if (window_we) begin
        win <= clamp_win(window_cfg);
      end
    end
  end

  always_ff @(posedge clk) begin
    cur      <= cur_next;
    st_idx   <= st_idx_next;
    st_full  <= st_full_next;
    rel_cnt  <= rel_cnt_next;
    pend_num <= pend_num_next;
    pend_tag <= pend_tag_next;
    result   <= result_next;
  end

endmodule
